>>> hdl/c6502_pkg.sv
package c6502_pkg;

	localparam logic [7:0] FLAG_C = 8'h01;
	localparam logic [7:0] FLAG_Z = 8'h02;
	localparam logic [7:0] FLAG_I = 8'h04;
	localparam logic [7:0] FLAG_D = 8'h08;
	localparam logic [7:0] FLAG_B = 8'h10;
	localparam logic [7:0] FLAG_U = 8'h20;
	localparam logic [7:0] FLAG_V = 8'h40;
	localparam logic [7:0] FLAG_N = 8'h80;

	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET  = 8'h34;

	typedef struct packed {
		logic [7:0] func;
		logic [7:0] operand;
	} exe_in_t;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] index_x;
		logic [7:0] index_y;
		logic [7:0] stack_ptr;
		logic [7:0] flags;
		logic [7:0] write_data;
		logic       write_enable;
		logic       branch_taken;
		logic       unknown_op;
	} exe_out_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] s;
		logic [7:0] p;
	} arch_t;

endpackage

>>> hdl/c6502_stream_if.sv
interface c6502_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/c6502_alu.sv
module c6502_alu (
	input  logic [7:0]      func,
	input  logic [7:0]      operand,
	input  c6502_pkg::arch_t cur,
	output c6502_pkg::arch_t nxt,
	output logic [7:0]      write_data,
	output logic            write_enable,
	output logic            branch_taken,
	output logic            unknown_op
);
	import c6502_pkg::*;

	logic [1:0] cc;
	logic [2:0] aaa;
	logic [2:0] bbb;

	function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] b);
		logic [7:0] r;
		r = p & ~(FLAG_N | FLAG_Z);
		if (b[7]) r = r | FLAG_N;
		if (b == 8'h00) r = r | FLAG_Z;
		return r;
	endfunction

	function automatic logic [15:0] adc(input logic [7:0] p, input logic [7:0] a,
		input logic [7:0] m);
		logic [8:0] sum;
		logic [7:0] r;
		sum = {1'b0, a} + {1'b0, m} + {8'h00, p[0]};
		r = p & ~(FLAG_V | FLAG_C);
		if ((~(a ^ m) & (a ^ sum[7:0]) & 8'h80) != 8'h00) r = r | FLAG_V;
		if (sum[8]) r = r | FLAG_C;
		r = nz(r, sum[7:0]);
		return {sum[7:0], r};
	endfunction

	function automatic logic [7:0] cmp(input logic [7:0] p, input logic [7:0] rg,
		input logic [7:0] m);
		logic [7:0] r;
		r = p & ~FLAG_C;
		if (rg >= m) r = r | FLAG_C;
		return nz(r, rg - m);
	endfunction

	function automatic logic [15:0] shf(input logic [7:0] p, input logic [1:0] k,
		input logic [7:0] v);
		logic [7:0] r;
		logic [7:0] q;
		q = p & ~FLAG_C;
		if (!k[1]) begin
			if (v[7]) q = q | FLAG_C;
			r = {v[6:0], k[0] & p[0]};
		end else begin
			if (v[0]) q = q | FLAG_C;
			r = {k[0] & p[0], v[7:1]};
		end
		return {r, nz(q, r)};
	endfunction

	always_comb begin
		logic [15:0] t;
		logic [7:0]  r;
		logic [7:0]  m;
		logic        fs;
		cc  = func[1:0];
		aaa = func[7:5];
		bbb = func[4:2];
		nxt = cur;
		write_data   = 8'h00;
		write_enable = 1'b0;
		branch_taken = 1'b0;
		unknown_op   = 1'b0;
		t  = 16'h0000;
		r  = 8'h00;
		m  = 8'h00;
		fs = 1'b0;
		case (cc)
			2'd1: begin
				if (aaa == 3'd4) begin
					if (bbb != 3'd2) begin
						write_data = cur.a;
						write_enable = 1'b1;
					end
				end else begin
					case (aaa)
						3'd0: begin nxt.a = cur.a | operand; nxt.p = nz(cur.p, nxt.a); end
						3'd1: begin nxt.a = cur.a & operand; nxt.p = nz(cur.p, nxt.a); end
						3'd2: begin nxt.a = cur.a ^ operand; nxt.p = nz(cur.p, nxt.a); end
						3'd3: begin t = adc(cur.p, cur.a, operand); nxt.a = t[15:8]; nxt.p = t[7:0]; end
						3'd5: begin nxt.a = operand; nxt.p = nz(cur.p, operand); end
						3'd6: nxt.p = cmp(cur.p, cur.a, operand);
						default: begin t = adc(cur.p, cur.a, ~operand); nxt.a = t[15:8]; nxt.p = t[7:0]; end
					endcase
				end
			end
			2'd3: begin
				if (bbb == 3'd2) begin
					if (func == 8'hEB) begin
						t = adc(cur.p, cur.a, ~operand);
						nxt.a = t[15:8];
						nxt.p = t[7:0];
					end else begin
						unknown_op = 1'b1;
					end
				end else if (aaa == 3'd4) begin
					if (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) begin
						write_data = cur.a & cur.x;
						write_enable = 1'b1;
					end else begin
						unknown_op = 1'b1;
					end
				end else if (aaa == 3'd5) begin
					if (bbb == 3'd6) begin
						unknown_op = 1'b1;
					end else begin
						nxt.a = operand;
						nxt.x = operand;
						nxt.p = nz(cur.p, operand);
					end
				end else begin
					case (aaa)
						3'd6: begin
							r = operand - 8'd1;
							nxt.p = cmp(cur.p, cur.a, r);
						end
						3'd7: begin
							r = operand + 8'd1;
							t = adc(cur.p, cur.a, ~r);
							nxt.a = t[15:8];
							nxt.p = t[7:0];
						end
						default: begin
							t = shf(cur.p, aaa[1:0], operand);
							r = t[15:8];
							case (aaa)
								3'd0: begin nxt.a = cur.a | r; nxt.p = nz(t[7:0], nxt.a); end
								3'd1: begin nxt.a = cur.a & r; nxt.p = nz(t[7:0], nxt.a); end
								3'd2: begin nxt.a = cur.a ^ r; nxt.p = nz(t[7:0], nxt.a); end
								default: begin
									t = adc(t[7:0], cur.a, r);
									nxt.a = t[15:8];
									nxt.p = t[7:0];
								end
							endcase
						end
					endcase
					write_data = r;
					write_enable = 1'b1;
				end
			end
			2'd2: begin
				if (bbb == 3'd4 || (bbb == 3'd7 && aaa == 3'd4)) begin
					unknown_op = 1'b1;
				end else if (bbb == 3'd2) begin
					case (aaa)
						3'd0, 3'd1, 3'd2, 3'd3: begin
							t = shf(cur.p, aaa[1:0], cur.a);
							nxt.a = t[15:8];
							nxt.p = t[7:0];
						end
						3'd4: begin nxt.a = cur.x; nxt.p = nz(cur.p, cur.x); end
						3'd5: begin nxt.x = cur.a; nxt.p = nz(cur.p, cur.a); end
						3'd6: begin nxt.x = cur.x - 8'd1; nxt.p = nz(cur.p, nxt.x); end
						default: ;
					endcase
				end else if (bbb == 3'd6) begin
					if (aaa == 3'd4) nxt.s = cur.x;
					else if (aaa == 3'd5) begin
						nxt.x = cur.s;
						nxt.p = nz(cur.p, cur.s);
					end
				end else if (bbb == 3'd0 && aaa != 3'd5) begin
					if (!aaa[2]) unknown_op = 1'b1;
				end else begin
					case (aaa)
						3'd4: begin write_data = cur.x; write_enable = 1'b1; end
						3'd5: begin nxt.x = operand; nxt.p = nz(cur.p, operand); end
						3'd6: begin
							r = operand - 8'd1;
							nxt.p = nz(cur.p, r);
							write_data = r;
							write_enable = 1'b1;
						end
						3'd7: begin
							r = operand + 8'd1;
							nxt.p = nz(cur.p, r);
							write_data = r;
							write_enable = 1'b1;
						end
						default: begin
							t = shf(cur.p, aaa[1:0], operand);
							nxt.p = t[7:0];
							write_data = t[15:8];
							write_enable = 1'b1;
						end
					endcase
				end
			end
			default: begin
				if (bbb == 3'd4) begin
					case (aaa[2:1])
						2'd0: fs = cur.p[7];
						2'd1: fs = cur.p[6];
						2'd2: fs = cur.p[0];
						default: fs = cur.p[1];
					endcase
					branch_taken = (fs == aaa[0]);
				end else if (bbb == 3'd6) begin
					case (aaa)
						3'd0: nxt.p = cur.p & ~FLAG_C;
						3'd1: nxt.p = cur.p | FLAG_C;
						3'd2: nxt.p = cur.p & ~FLAG_I;
						3'd3: nxt.p = cur.p | FLAG_I;
						3'd4: begin nxt.a = cur.y; nxt.p = nz(cur.p, cur.y); end
						3'd5: nxt.p = cur.p & ~FLAG_V;
						3'd6: nxt.p = cur.p & ~FLAG_D;
						default: nxt.p = cur.p | FLAG_D;
					endcase
				end else if (bbb == 3'd2) begin
					case (aaa)
						3'd0: begin
							write_data = cur.p | FLAG_B | FLAG_U;
							write_enable = 1'b1;
							nxt.s = cur.s - 8'd1;
						end
						3'd1: begin
							nxt.s = cur.s + 8'd1;
							nxt.p = (operand & 8'hCF) | FLAG_U;
						end
						3'd2: begin
							write_data = cur.a;
							write_enable = 1'b1;
							nxt.s = cur.s - 8'd1;
						end
						3'd3: begin
							nxt.s = cur.s + 8'd1;
							nxt.a = operand;
							nxt.p = nz(cur.p, operand);
						end
						3'd4: begin nxt.y = cur.y - 8'd1; nxt.p = nz(cur.p, nxt.y); end
						3'd5: begin nxt.y = cur.a; nxt.p = nz(cur.p, cur.a); end
						3'd6: begin nxt.y = cur.y + 8'd1; nxt.p = nz(cur.p, nxt.y); end
						default: begin nxt.x = cur.x + 8'd1; nxt.p = nz(cur.p, nxt.x); end
					endcase
				end else begin
					case (aaa)
						3'd0: if (bbb == 3'd0) unknown_op = 1'b1;
						3'd1: begin
							if (bbb == 3'd0) unknown_op = 1'b1;
							else if (bbb == 3'd1 || bbb == 3'd3) begin
								m = cur.p & ~(FLAG_Z | FLAG_N | FLAG_V);
								if ((cur.a & operand) == 8'h00) m = m | FLAG_Z;
								m = m | (operand & (FLAG_N | FLAG_V));
								nxt.p = m;
							end
						end
						3'd2, 3'd3: if (bbb == 3'd0 || bbb == 3'd3) unknown_op = 1'b1;
						3'd4: begin
							if (bbb == 3'd7) unknown_op = 1'b1;
							else if (bbb != 3'd0) begin
								write_data = cur.y;
								write_enable = 1'b1;
							end
						end
						3'd5: begin nxt.y = operand; nxt.p = nz(cur.p, operand); end
						3'd6: if (bbb <= 3'd3) nxt.p = cmp(cur.p, cur.y, operand);
						default: if (bbb <= 3'd3) nxt.p = cmp(cur.p, cur.x, operand);
					endcase
				end
			end
		endcase
	end
endmodule

>>> hdl/cpu6502_execute_unit_core.sv
// Execute stage of a 6502 without decimal mode. One opcode with its
// fetched operand byte enters per cycle; its result, including the A, X, Y, S and
// P values after the opcode, appears on the result channel in the next cycle. The
// architectural registers update in the same cycle as the item is taken, so back
// to back opcodes see each other's effects. A full result register stalls input
// only while the result side is not ready. Unsupported opcodes change nothing and
// report unknown_op. After reset A=X=Y=0, S=0xFD, P=0x34.
module cpu6502_execute_unit_core (
	input logic clk,
	input logic arst_n,
	c6502_stream_if.sink   in_ch,
	c6502_stream_if.source out_ch
);
	import c6502_pkg::*;

	arch_t      regs_q;
	arch_t      nxt;
	logic [7:0] wd;
	logic       we;
	logic       br;
	logic       unk;
	logic       out_valid_q;
	exe_out_t   out_q;
	logic       take;

	c6502_alu u_alu (
		.func(in_ch.payload.func),
		.operand(in_ch.payload.operand),
		.cur(regs_q),
		.nxt(nxt),
		.write_data(wd),
		.write_enable(we),
		.branch_taken(br),
		.unknown_op(unk)
	);

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: SP_RESET, p: P_RESET};
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				regs_q <= nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= '{acc: nxt.a, index_x: nxt.x, index_y: nxt.y, stack_ptr: nxt.s,
				flags: nxt.p, write_data: wd, write_enable: we, branch_taken: br,
				unknown_op: unk};
		end
	end

	a_flag5: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.flags[5])
		else $error("flags bit 5 clear in result");

	a_regs5: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.p[5])
		else $error("status bit 5 clear");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("result changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty result register");
endmodule
